FILE: sv/assert_macros.svh
// assertion helpers for the cramer solver
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_NEVER(label, clk, rst_n, expr)

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/cs3_pkg.sv
package cs3_pkg;

  localparam int COEF_W     = 16;
  localparam int OUT_W      = 32;
  localparam int OUT_FRAC   = 16;
  localparam int NUM_IN     = 12;
  localparam int NUM_LANE   = 3;
  localparam int PRD_W      = 2 * COEF_W;
  localparam int MIN_W      = 2 * COEF_W + 1;
  localparam int TRM_W      = COEF_W + MIN_W;
  localparam int DET_W      = 3 * COEF_W + 4;
  localparam int NEXT_W     = DET_W + OUT_W;
  localparam int IN_DATA_W  = NUM_IN * COEF_W;
  localparam int OUT_DATA_W = NUM_LANE * OUT_W;
  localparam int USER_W     = 2;
  localparam int USER_SING  = 0;
  localparam int USER_OVF   = 1;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;
  localparam logic [CNT_W-1:0] FIFO_FULL_CNT = CNT_W'(FIFO_DEPTH);

  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef struct packed {
    det_t den;
    det_t num_x;
    det_t num_y;
    det_t num_z;
    logic singular;
  } sys_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic [DET_W-1:0] rem;
    logic [OUT_W-1:0] lo;
    logic [OUT_W-1:0] quo;
    logic             neg;
    logic             big;
  } lane_t;

endpackage

FILE: sv/cs3_front.sv
module cs3_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_vld_i,
  input  logic [cs3_pkg::IN_DATA_W-1:0] in_data_i,
  output logic                          out_vld_o,
  output cs3_pkg::sys_t                 out_sys_o
);

  cs3_pkg::coef_t c [cs3_pkg::NUM_IN];

  for (genvar k = 0; k < cs3_pkg::NUM_IN; k++) begin : g_unpack
    assign c[k] = in_data_i[k*cs3_pkg::COEF_W +: cs3_pkg::COEF_W];
  end

  logic [3:0] vld_q;

  logic signed [cs3_pkg::PRD_W-1:0] pr_q [12];
  logic signed [cs3_pkg::MIN_W-1:0] mn_q [6];
  logic signed [cs3_pkg::TRM_W-1:0] tm_q [12];
  cs3_pkg::coef_t a1_q, b1_q, c1_q, p1_q;
  cs3_pkg::coef_t a2_q, b2_q, c2_q, p2_q;
  cs3_pkg::sys_t  sys_q;
  cs3_pkg::sys_t  sys_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_vld_i};
    end
  end

  // d=m10 e=m11 f=m12 g=m20 h=m21 i=m22 q=rhs1 r=rhs2
  always_ff @(posedge clk_i) begin
    pr_q[0]  <= cs3_pkg::PRD_W'(c[4])  * cs3_pkg::PRD_W'(c[8]);
    pr_q[1]  <= cs3_pkg::PRD_W'(c[5])  * cs3_pkg::PRD_W'(c[7]);
    pr_q[2]  <= cs3_pkg::PRD_W'(c[3])  * cs3_pkg::PRD_W'(c[8]);
    pr_q[3]  <= cs3_pkg::PRD_W'(c[5])  * cs3_pkg::PRD_W'(c[6]);
    pr_q[4]  <= cs3_pkg::PRD_W'(c[3])  * cs3_pkg::PRD_W'(c[7]);
    pr_q[5]  <= cs3_pkg::PRD_W'(c[4])  * cs3_pkg::PRD_W'(c[6]);
    pr_q[6]  <= cs3_pkg::PRD_W'(c[10]) * cs3_pkg::PRD_W'(c[8]);
    pr_q[7]  <= cs3_pkg::PRD_W'(c[5])  * cs3_pkg::PRD_W'(c[11]);
    pr_q[8]  <= cs3_pkg::PRD_W'(c[10]) * cs3_pkg::PRD_W'(c[7]);
    pr_q[9]  <= cs3_pkg::PRD_W'(c[4])  * cs3_pkg::PRD_W'(c[11]);
    pr_q[10] <= cs3_pkg::PRD_W'(c[3])  * cs3_pkg::PRD_W'(c[11]);
    pr_q[11] <= cs3_pkg::PRD_W'(c[10]) * cs3_pkg::PRD_W'(c[6]);
    a1_q <= c[0];
    b1_q <= c[1];
    c1_q <= c[2];
    p1_q <= c[9];

    for (int k = 0; k < 6; k++) begin
      mn_q[k] <= cs3_pkg::MIN_W'(pr_q[2*k]) - cs3_pkg::MIN_W'(pr_q[2*k+1]);
    end
    a2_q <= a1_q;
    b2_q <= b1_q;
    c2_q <= c1_q;
    p2_q <= p1_q;

    // minors: 0 ei-fh, 1 di-fg, 2 dh-eg, 3 qi-fr, 4 qh-er, 5 dr-qg
    tm_q[0]  <= cs3_pkg::TRM_W'(a2_q) * cs3_pkg::TRM_W'(mn_q[0]);
    tm_q[1]  <= cs3_pkg::TRM_W'(b2_q) * cs3_pkg::TRM_W'(mn_q[1]);
    tm_q[2]  <= cs3_pkg::TRM_W'(c2_q) * cs3_pkg::TRM_W'(mn_q[2]);
    tm_q[3]  <= cs3_pkg::TRM_W'(p2_q) * cs3_pkg::TRM_W'(mn_q[0]);
    tm_q[4]  <= cs3_pkg::TRM_W'(b2_q) * cs3_pkg::TRM_W'(mn_q[3]);
    tm_q[5]  <= cs3_pkg::TRM_W'(c2_q) * cs3_pkg::TRM_W'(mn_q[4]);
    tm_q[6]  <= cs3_pkg::TRM_W'(a2_q) * cs3_pkg::TRM_W'(mn_q[3]);
    tm_q[7]  <= cs3_pkg::TRM_W'(p2_q) * cs3_pkg::TRM_W'(mn_q[1]);
    tm_q[8]  <= cs3_pkg::TRM_W'(c2_q) * cs3_pkg::TRM_W'(mn_q[5]);
    tm_q[9]  <= cs3_pkg::TRM_W'(a2_q) * cs3_pkg::TRM_W'(mn_q[4]);
    tm_q[10] <= cs3_pkg::TRM_W'(b2_q) * cs3_pkg::TRM_W'(mn_q[5]);
    tm_q[11] <= cs3_pkg::TRM_W'(p2_q) * cs3_pkg::TRM_W'(mn_q[2]);

    sys_q <= sys_d;
  end

  always_comb begin
    sys_d.den   = cs3_pkg::DET_W'(tm_q[0]) - cs3_pkg::DET_W'(tm_q[1])
                + cs3_pkg::DET_W'(tm_q[2]);
    sys_d.num_x = cs3_pkg::DET_W'(tm_q[3]) - cs3_pkg::DET_W'(tm_q[4])
                + cs3_pkg::DET_W'(tm_q[5]);
    sys_d.num_y = cs3_pkg::DET_W'(tm_q[6]) - cs3_pkg::DET_W'(tm_q[7])
                + cs3_pkg::DET_W'(tm_q[8]);
    sys_d.num_z = cs3_pkg::DET_W'(tm_q[11]) - cs3_pkg::DET_W'(tm_q[9])
                - cs3_pkg::DET_W'(tm_q[10]);
    sys_d.singular = (sys_d.den == '0);
  end

  assign out_vld_o = vld_q[3];
  assign out_sys_o = sys_q;

endmodule

FILE: sv/cs3_fifo.sv
module cs3_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cs3_pkg::sys_t       push_data_i,
  input  logic                pop_i,
  output cs3_pkg::sys_t       pop_data_o,
  output cs3_pkg::fifo_stat_t stat_o
);

  cs3_pkg::sys_t ent_q [cs3_pkg::FIFO_DEPTH];

  logic [cs3_pkg::FIFO_AW-1:0] wr_q, rd_q;
  logic [cs3_pkg::CNT_W-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + cs3_pkg::CNT_W'(push_i) - cs3_pkg::CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = ent_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == cs3_pkg::FIFO_FULL_CNT);

endmodule

FILE: sv/cs3_back.sv
module cs3_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cs3_pkg::fifo_stat_t            stat_i,
  input  cs3_pkg::sys_t                  sys_i,
  output logic                           pop_o,
  output logic                           out_vld_o,
  input  logic                           out_rdy_i,
  output logic [cs3_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic [cs3_pkg::USER_W-1:0]     out_user_o
);

  localparam int NS = cs3_pkg::OUT_W;

  logic en;
  assign en    = !out_vld_o || out_rdy_i;
  assign pop_o = en && !stat_i.empty;

  // operand prep stage
  logic                      p0_vld_q;
  logic                      p0_sing_q;
  logic [cs3_pkg::DET_W-1:0] p0_den_q;
  logic [cs3_pkg::DET_W-1:0] p0_num_q [cs3_pkg::NUM_LANE];
  logic                      p0_neg_q [cs3_pkg::NUM_LANE];
  cs3_pkg::det_t             num_in   [cs3_pkg::NUM_LANE];

  assign num_in[0] = sys_i.num_x;
  assign num_in[1] = sys_i.num_y;
  assign num_in[2] = sys_i.num_z;

  // divider stages, one quotient bit each
  logic [NS:0]               vl_q;
  logic                      sg_q [NS+1];
  logic [cs3_pkg::DET_W-1:0] dv_q [NS+1];
  cs3_pkg::lane_t            ln_q [NS+1][cs3_pkg::NUM_LANE];
  cs3_pkg::lane_t            ln_d [NS+1][cs3_pkg::NUM_LANE];

  logic                              out_vld_q;
  logic [cs3_pkg::OUT_DATA_W-1:0]    out_data_q, out_data_d;
  logic [cs3_pkg::USER_W-1:0]        out_user_q, out_user_d;

  always_comb begin
    logic [cs3_pkg::NEXT_W-1:0] ext;
    logic [cs3_pkg::DET_W:0]    trial;
    logic                       qb;
    for (int l = 0; l < cs3_pkg::NUM_LANE; l++) begin
      ext = cs3_pkg::NEXT_W'(p0_num_q[l]) << cs3_pkg::OUT_FRAC;
      ln_d[0][l].rem = ext[cs3_pkg::NEXT_W-1:cs3_pkg::OUT_W];
      ln_d[0][l].lo  = ext[cs3_pkg::OUT_W-1:0];
      ln_d[0][l].quo = '0;
      ln_d[0][l].neg = p0_neg_q[l];
      // quotient of at least 2^OUT_W saturates whatever the sign
      ln_d[0][l].big = (ext[cs3_pkg::NEXT_W-1:cs3_pkg::OUT_W] >= p0_den_q);
    end
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < cs3_pkg::NUM_LANE; l++) begin
        trial = {ln_q[s][l].rem, ln_q[s][l].lo[cs3_pkg::OUT_W-1]};
        qb    = (trial >= {1'b0, dv_q[s]});
        if (qb) begin
          trial = trial - {1'b0, dv_q[s]};
        end
        ln_d[s+1][l].rem = trial[cs3_pkg::DET_W-1:0];
        ln_d[s+1][l].lo  = {ln_q[s][l].lo[cs3_pkg::OUT_W-2:0], 1'b0};
        ln_d[s+1][l].quo = {ln_q[s][l].quo[cs3_pkg::OUT_W-2:0], qb};
        ln_d[s+1][l].neg = ln_q[s][l].neg;
        ln_d[s+1][l].big = ln_q[s][l].big;
      end
    end
  end

  always_comb begin
    logic                     sat;
    logic [cs3_pkg::OUT_W-1:0] q;
    logic [cs3_pkg::OUT_W-1:0] val;
    logic                     ovf;
    ovf = 1'b0;
    for (int l = 0; l < cs3_pkg::NUM_LANE; l++) begin
      q   = ln_q[NS][l].quo;
      sat = ln_q[NS][l].big ||
            (ln_q[NS][l].neg ? (q[cs3_pkg::OUT_W-1] && (|q[cs3_pkg::OUT_W-2:0]))
                             : q[cs3_pkg::OUT_W-1]);
      if (sat) begin
        val = ln_q[NS][l].neg ? cs3_pkg::SAT_NEG : cs3_pkg::SAT_POS;
      end else begin
        val = ln_q[NS][l].neg ? (~q + 1'b1) : q;
      end
      if (sg_q[NS]) begin
        val = '0;
        sat = 1'b0;
      end
      ovf = ovf || sat;
      out_data_d[l*cs3_pkg::OUT_W +: cs3_pkg::OUT_W] = val;
    end
    out_user_d = '0;
    out_user_d[cs3_pkg::USER_SING] = sg_q[NS];
    out_user_d[cs3_pkg::USER_OVF]  = ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q  <= 1'b0;
      vl_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p0_vld_q  <= pop_o;
      vl_q      <= {vl_q[NS-1:0], p0_vld_q};
      out_vld_q <= vl_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_sing_q <= sys_i.singular;
      p0_den_q  <= sys_i.den[cs3_pkg::DET_W-1] ? (~sys_i.den + 1'b1) : sys_i.den;
      for (int l = 0; l < cs3_pkg::NUM_LANE; l++) begin
        p0_num_q[l] <= num_in[l][cs3_pkg::DET_W-1] ? (~num_in[l] + 1'b1) : num_in[l];
        p0_neg_q[l] <= num_in[l][cs3_pkg::DET_W-1] ^ sys_i.den[cs3_pkg::DET_W-1];
      end
      sg_q[0] <= p0_sing_q;
      dv_q[0] <= p0_den_q;
      for (int s = 0; s < NS; s++) begin
        sg_q[s+1] <= sg_q[s];
        dv_q[s+1] <= dv_q[s];
      end
      for (int s = 0; s <= NS; s++) begin
        for (int l = 0; l < cs3_pkg::NUM_LANE; l++) begin
          ln_q[s][l] <= ln_d[s][l];
        end
      end
      if (vl_q[NS]) begin
        out_data_q <= out_data_d;
        out_user_q <= out_user_d;
      end
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

endmodule

FILE: sv/cramer_solver_3x3.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: m00..m22, rhs0..rhs2, 16 bit each
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: sol_x, sol_y, sol_z; tuser: flags
//
// one system per cycle sustained while m_axis_tready does not stall the output; stages: 4 determinant
// stages, the queue, 2 divider setup stages, 32 quotient-bit stages, output reg
// rst_ni clears handshake, valid, queue pointer and word count state only
// input side stalls only when the determinant pipe and the 8-entry queue together hold 8 words
// output stall freezes the divider pipe; the determinant pipe keeps filling the queue
`include "assert_macros.svh"

module cramer_solver_3x3 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, rhs0, rhs1, rhs2
  input  logic [cs3_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // sol_x, sol_y, sol_z
  output logic [cs3_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // singular, overflow
  output logic [cs3_pkg::USER_W-1:0]     m_axis_tuser
);

  logic                      s_acc;
  logic                      push_vld;
  logic                      pop;
  cs3_pkg::sys_t             push_sys;
  cs3_pkg::sys_t             pop_sys;
  cs3_pkg::fifo_stat_t       fifo_stat;
  logic [cs3_pkg::CNT_W-1:0] cnt_q, cnt_d;

  // words in the determinant pipe plus the queue
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (cnt_q < cs3_pkg::FIFO_FULL_CNT);
  assign cnt_d         = cnt_q + cs3_pkg::CNT_W'(s_acc) - cs3_pkg::CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  cs3_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s_acc),
    .in_data_i (s_axis_tdata),
    .out_vld_o (push_vld),
    .out_sys_o (push_sys)
  );

  cs3_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_vld),
    .push_data_i (push_sys),
    .pop_i       (pop),
    .pop_data_o  (pop_sys),
    .stat_o      (fifo_stat)
  );

  cs3_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (fifo_stat),
    .sys_i      (pop_sys),
    .pop_o      (pop),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

  `ASSERT_NEVER(a_credit_bound, clk_i, rst_ni, cnt_q > cs3_pkg::FIFO_FULL_CNT)
  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_vld && fifo_stat.full && !pop)
  `ASSERT_IMPLIES(a_sing_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[cs3_pkg::USER_SING], m_axis_tdata == '0 && !m_axis_tuser[cs3_pkg::USER_OVF])

endmodule
